>>> design/tfcm_pkg.sv
// Package for the thermal false-color mapper: palette and register codes,
// fixed widths and the reciprocal constants of the palette index scaling.
// No dependencies.
`default_nettype none

package tfcm_pkg;

  // Palette index and pixel widths
  localparam int IDX_W = 8;
  localparam int PIX_W = 16;

  // Configuration register index width and codes
  localparam int CFG_ADDR_W = 2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FRAME_MAX    = 2'd0,
    REG_FRAME_MIN    = 2'd1,
    REG_PALETTE_MODE = 2'd2,
    REG_UNUSED       = 2'd3
  } cfg_reg_t;

  // Palette select codes
  typedef enum logic [1:0] {
    MODE_IRON    = 2'd0,
    MODE_GRAY    = 2'd1,
    MODE_RAINBOW = 2'd2,
    MODE_BLACK   = 2'd3
  } palette_mode_t;

  // Iron: floor(7*idx/10) = (idx * IRON_MUL) >> IRON_SH, exact for idx < 256
  // Rainbow: floor(240*idx/255) = (idx * RAIN_MUL) >> RAIN_SH, exact likewise
  localparam int MUL_W  = 20;
  localparam int PROD_W = IDX_W + MUL_W;
  localparam logic [MUL_W-1:0] IRON_MUL = 20'd367003;
  localparam int               IRON_SH  = 19;
  localparam logic [MUL_W-1:0] RAIN_MUL = 20'd986896;
  localparam int               RAIN_SH  = 20;

  // Iron palette offset added after scaling
  localparam logic [IDX_W-1:0] IRON_BASE = 8'd20;

endpackage

`default_nettype wire

>>> design/tfcm_scale.sv
// Front stage of the mapper: forms |(sample - min + 1) * 255| and the sign of
// the quotient, plus |max - min + 2| and its zero flag from the frame registers.
// Uses no package items.
`default_nettype none

module tfcm_scale #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           ce,
  input  wire                           in_valid,
  input  wire signed [SAMPLE_BITS-1:0]  sample,
  input  wire signed [SAMPLE_BITS-1:0]  frame_min,
  input  wire signed [SAMPLE_BITS-1:0]  frame_max,
  output logic                          out_valid,
  output logic [SAMPLE_BITS+7:0]        num_mag,
  output logic                          q_neg,
  output logic [SAMPLE_BITS:0]          den_mag,
  output logic                          den_zero
);

  localparam int EW = SAMPLE_BITS + 2;   // difference width
  localparam int MW = SAMPLE_BITS + 10;  // scaled numerator width
  localparam int NW = SAMPLE_BITS + 8;   // numerator magnitude width
  localparam int DW = SAMPLE_BITS + 1;   // divisor magnitude width

  logic signed [EW-1:0] diff;
  logic signed [MW-1:0] num;
  logic signed [MW-1:0] num_abs;
  logic signed [EW-1:0] den;
  logic signed [EW-1:0] den_abs;

  // Numerator: (sample - min + 1) * 255 as shift and subtract
  assign diff    = EW'(sample) - EW'(frame_min) + EW'(1);
  assign num     = (MW'(diff) <<< 8) - MW'(diff);
  assign num_abs = num[MW-1] ? -num : num;

  // Divisor from the frame registers; the user must keep them stable while items are in flight, not enforced here
  assign den     = EW'(frame_max) - EW'(frame_min) + EW'(2);
  assign den_abs = den[EW-1] ? -den : den;

  // Item register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      num_mag <= num_abs[NW-1:0];
      q_neg   <= num[MW-1] ^ den[EW-1];
    end
  end

  // Divisor register, refreshed every cycle
  always_ff @(posedge clk) begin
    den_mag  <= den_abs[DW-1:0];
    den_zero <= (den == '0);
  end

endmodule

`default_nettype wire

>>> design/tfcm_div.sv
// Pipelined restoring divider: one quotient bit per stage, keeps only the
// low 8 quotient bits. Depends on tfcm_pkg for the index width.
`default_nettype none

module tfcm_div #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 17
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        ce,
  input  wire                        in_valid,
  input  wire  [NUM_W-1:0]           num_mag,
  input  wire                        in_neg,
  input  wire  [DEN_W-1:0]           den_mag,
  output logic                       out_valid,
  output logic [tfcm_pkg::IDX_W-1:0] q_low,
  output logic                       out_neg
);

  localparam int QW = tfcm_pkg::IDX_W;

  // Stage registers, one entry per quotient bit
  logic             vld_r [NUM_W];
  logic [DEN_W-1:0] rem_r [NUM_W];
  logic [NUM_W-1:0] num_r [NUM_W];
  logic [QW-1:0]    q_r   [NUM_W];
  logic             neg_r [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic             vld_in;
    logic [DEN_W-1:0] rem_in;
    logic [NUM_W-1:0] num_in;
    logic [QW-1:0]    q_in;
    logic             neg_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign vld_in = in_valid;
      assign rem_in = '0;
      assign num_in = num_mag;
      assign q_in   = '0;
      assign neg_in = in_neg;
    end else begin : g_next
      assign vld_in = vld_r[k-1];
      assign rem_in = rem_r[k-1];
      assign num_in = num_r[k-1];
      assign q_in   = q_r[k-1];
      assign neg_in = neg_r[k-1];
    end

    // Shift in the next numerator bit, subtract when it fits
    assign trial = {rem_in, num_in[NUM_W-1]};
    assign diff  = trial - {1'b0, den_mag};
    assign ge    = (trial >= {1'b0, den_mag});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[k] <= 1'b0;
      end else if (ce) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        num_r[k] <= {num_in[NUM_W-2:0], 1'b0};
        q_r[k]   <= {q_in[QW-2:0], ge};
        neg_r[k] <= neg_in;
      end
    end
  end

  assign out_valid = vld_r[NUM_W-1];
  assign q_low     = q_r[NUM_W-1];
  assign out_neg   = neg_r[NUM_W-1];

endmodule

`default_nettype wire

>>> design/tfcm_palette.sv
// Palette back end: signed fix-up of the quotient into the 8-bit index,
// palette position scaling, then the color ramps and RGB565 packing.
// Depends on tfcm_pkg for codes, widths and scaling constants.
`default_nettype none

module tfcm_palette (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            ce,
  input  wire                            in_valid,
  input  wire  [tfcm_pkg::IDX_W-1:0]     q_low,
  input  wire                            q_neg,
  input  wire                            den_zero,
  input  tfcm_pkg::palette_mode_t        mode,
  output logic                           out_valid,
  output logic [tfcm_pkg::PIX_W-1:0]     pixel
);

  localparam int IW = tfcm_pkg::IDX_W;

  logic [IW-1:0]               idx;
  logic [tfcm_pkg::PROD_W-1:0] prod_iron;
  logic [tfcm_pkg::PROD_W-1:0] prod_rain;

  // Stage A registers
  logic          vld_a;
  logic [IW-1:0] idx_a;
  logic [IW-1:0] n_iron;
  logic [IW-1:0] n_rain;

  // Stage B color channels
  logic [IW-1:0] r_v;
  logic [IW-1:0] g_v;
  logic [IW-1:0] b_v;
  logic [IW-1:0] off_v;
  logic [IW-1:0] rise_v;

  // Index: low byte of the signed quotient, zero divisor gives zero
  assign idx = den_zero ? '0 : (q_neg ? (IW'(0) - q_low) : q_low);

  // Position along each palette by reciprocal multiply
  assign prod_iron = tfcm_pkg::PROD_W'(idx) * tfcm_pkg::PROD_W'(tfcm_pkg::IRON_MUL);
  assign prod_rain = tfcm_pkg::PROD_W'(idx) * tfcm_pkg::PROD_W'(tfcm_pkg::RAIN_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
    end else if (ce) begin
      vld_a <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      idx_a  <= idx;
      n_iron <= prod_iron[tfcm_pkg::IRON_SH +: IW] + tfcm_pkg::IRON_BASE;
      n_rain <= prod_rain[tfcm_pkg::RAIN_SH +: IW];
    end
  end

  // Color ramps
  always_comb begin
    r_v    = '0;
    g_v    = '0;
    b_v    = '0;
    off_v  = '0;
    rise_v = '0;
    case (mode)
      tfcm_pkg::MODE_IRON: begin
        if (n_iron < 8'd64) begin
          b_v = {n_iron[5:0], 2'b00};
        end else if (n_iron < 8'd96) begin
          off_v = n_iron - 8'd64;
          b_v   = 8'hFF;
          r_v   = {off_v[5:0], 2'b00};
        end else if (n_iron < 8'd128) begin
          off_v  = n_iron - 8'd95;
          rise_v = n_iron - 8'd64;
          b_v    = 8'd0 - {off_v[4:0], 3'b000};
          r_v    = {rise_v[5:0], 2'b00} - 8'd1;
        end else if (n_iron < 8'd191) begin
          off_v = n_iron - 8'd128;
          g_v   = {off_v[5:0], 2'b00};
          r_v   = 8'hFF;
        end else begin
          off_v = n_iron - 8'd191;
          b_v   = {off_v[5:0], 2'b00};
          g_v   = 8'hFF;
          r_v   = 8'hFF;
        end
      end
      tfcm_pkg::MODE_GRAY: begin
        r_v = idx_a;
        g_v = idx_a;
        b_v = idx_a;
      end
      tfcm_pkg::MODE_RAINBOW: begin
        if (n_rain < 8'd60) begin
          b_v = 8'hFF;
          g_v = {n_rain[5:0], 2'b00};
        end else if (n_rain < 8'd120) begin
          off_v = 8'd120 - n_rain;
          b_v   = {off_v[5:0], 2'b00};
          g_v   = 8'hFF;
        end else if (n_rain < 8'd180) begin
          off_v = n_rain - 8'd119;
          g_v   = 8'hFF;
          r_v   = {off_v[5:0], 2'b00};
        end else begin
          off_v = 8'd240 - n_rain;
          g_v   = {off_v[5:0], 2'b00};
          r_v   = 8'hFF;
        end
      end
      default: begin
        r_v = '0;
      end
    endcase
  end

  // Stage B: packed RGB565, bit 5 zero
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= vld_a;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      pixel <= {r_v[7:3], g_v[7:3], 1'b0, b_v[7:3]};
    end
  end

endmodule

`default_nettype wire

>>> design/thermal_false_color_mapper_top.sv
// Top level of the thermal false-color mapper: configuration registers,
// scale front end, pipelined divider, palette back end and output skid.
// Depends on tfcm_pkg, tfcm_scale, tfcm_div and tfcm_palette.
//
//   channel  direction  signals                       payload
//   s_*      in         s_tvalid s_tready s_tdata     sample
//   m_*      out        m_tvalid m_tready m_tdata     pixel_rgb565
//   cfg_*    in         cfg_we cfg_addr cfg_wdata     frame_max, frame_min, palette_mode
//
// One sample accepted per cycle while the skid is empty; each sample passes the scale
// register, the divider (one stage per quotient bit), palette stages A and B and the output register.
// rst is synchronous and clears all valid bits; configuration resets to
// max 255, min 0, iron palette.
// A held result fills the skid register; the pipeline then freezes as a whole
// until the skid drains, so nothing is dropped or repeated.
`default_nettype none

module thermal_false_color_mapper_top #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire                                  clk,
  input  wire                                  rst,
  // sample in bits [SAMPLE_BITS-1:0], zero padded to whole bytes
  input  wire  [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,
  input  wire                                  s_tvalid,
  output logic                                 s_tready,
  // pixel_rgb565 in bits [15:0]
  output logic [tfcm_pkg::PIX_W-1:0]           m_tdata,
  output logic                                 m_tvalid,
  input  wire                                  m_tready,
  input  wire                                  cfg_we,
  input  wire  [tfcm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  wire  [SAMPLE_BITS-1:0]               cfg_wdata
);

  localparam int NW = SAMPLE_BITS + 8;
  localparam int DW = SAMPLE_BITS + 1;

  // Configuration registers
  logic signed [SAMPLE_BITS-1:0] frame_max;
  logic signed [SAMPLE_BITS-1:0] frame_min;
  tfcm_pkg::palette_mode_t       palette_mode;

  logic                          ce;
  logic                          sc_valid;
  logic [NW-1:0]                 sc_num;
  logic                          sc_neg;
  logic [DW-1:0]                 den_mag;
  logic                          den_zero;
  logic                          dv_valid;
  logic [tfcm_pkg::IDX_W-1:0]    dv_q;
  logic                          dv_neg;
  logic                          pal_valid;
  logic [tfcm_pkg::PIX_W-1:0]    pal_pixel;
  logic                          skid_valid;
  logic [tfcm_pkg::PIX_W-1:0]    skid_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_max    <= SAMPLE_BITS'(255);
      frame_min    <= '0;
      palette_mode <= tfcm_pkg::MODE_IRON;
    end else if (cfg_we) begin
      case (tfcm_pkg::cfg_reg_t'(cfg_addr))
        tfcm_pkg::REG_FRAME_MAX:    frame_max    <= cfg_wdata;
        tfcm_pkg::REG_FRAME_MIN:    frame_min    <= cfg_wdata;
        tfcm_pkg::REG_PALETTE_MODE: palette_mode <= tfcm_pkg::palette_mode_t'(cfg_wdata[1:0]);
        default: begin
        end
      endcase
    end
  end

  // Whole pipeline advances unless the skid holds a result
  assign ce       = !skid_valid;
  assign s_tready = ce;

  tfcm_scale #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_scale (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (s_tvalid),
    .sample   (s_tdata[SAMPLE_BITS-1:0]),
    .frame_min(frame_min),
    .frame_max(frame_max),
    .out_valid(sc_valid),
    .num_mag  (sc_num),
    .q_neg    (sc_neg),
    .den_mag  (den_mag),
    .den_zero (den_zero)
  );

  tfcm_div #(
    .NUM_W(NW),
    .DEN_W(DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (sc_valid),
    .num_mag  (sc_num),
    .in_neg   (sc_neg),
    .den_mag  (den_mag),
    .out_valid(dv_valid),
    .q_low    (dv_q),
    .out_neg  (dv_neg)
  );

  tfcm_palette u_palette (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (dv_valid),
    .q_low    (dv_q),
    .q_neg    (dv_neg),
    .den_zero (den_zero),
    .mode     (palette_mode),
    .out_valid(pal_valid),
    .pixel    (pal_pixel)
  );

  // Output register and skid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_tready) begin
        skid_valid <= 1'b0;
      end
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= pal_valid;
    end else if (pal_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (m_tready) begin
        m_tdata <= skid_pixel;
      end
    end else if (!m_tvalid || m_tready) begin
      m_tdata <= pal_pixel;
    end else begin
      skid_pixel <= pal_pixel;
    end
  end

endmodule

`default_nettype wire

>>> dv/tb_thermal_false_color_mapper_top.sv
// Self-checking testbench for thermal_false_color_mapper_top: a queue-fed
// stream driver, a result monitor and a pixel predictor.
// Depends on tfcm_pkg and the mapper RTL.
`default_nettype none

module tb_thermal_false_color_mapper_top;
  import tfcm_pkg::*;

  localparam int SAMPLE_BITS  = 16;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 228;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;   // pipeline is 28 deep plus skid
  localparam int LIMIT        = 200000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic [15:0]            s_tdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [15:0]            m_tdata;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic                   cfg_we = 1'b0;
  cfg_reg_t               cfg_addr = REG_FRAME_MAX;
  logic [SAMPLE_BITS-1:0] cfg_wdata = '0;

  // Samples waiting to be sent and pixels waiting to come back
  logic [15:0] sample_q[$];
  logic [15:0] pixel_q[$];

  // Shadow of the configuration registers
  logic signed [15:0] frame_max_r = 16'sd255;
  logic signed [15:0] frame_min_r = 16'sd0;
  palette_mode_t      mode_r = MODE_IRON;

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_cnt = 0;
  int err_cnt = 0;
  int cycle_cnt = 0;

  thermal_false_color_mapper_top #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
    .clk(clk),
    .rst(rst),
    .s_tdata(s_tdata),   // sample [15:0]
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata(m_tdata),   // pixel_rgb565 [15:0]
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Color of one sample under the current frame range and palette
  function automatic logic [15:0] pixel_for(logic signed [15:0] smp);
    longint num, den, q;
    int idx, n, r, g, b;
    r = 0;
    g = 0;
    b = 0;
    num = (longint'(smp) - longint'(frame_min_r) + 1) * 255;
    den = longint'(frame_max_r) - longint'(frame_min_r) + 2;
    // zero divisor gives index 0; otherwise truncate toward zero, keep 8 bits
    if (den == 0) idx = 0;
    else begin
      q = num / den;
      idx = int'(q & 64'hFF);
    end
    case (mode_r)
      MODE_IRON: begin
        n = (7 * idx) / 10 + 20;
        if (n < 64) begin
          b = 4 * n;
        end else if (n < 96) begin
          b = 255;
          r = 4 * (n - 64);
        end else if (n < 128) begin
          b = (256 - 8 * (n - 95)) & 'hFF;
          r = (4 * (n - 64) - 1) & 'hFF;
        end else if (n < 191) begin
          g = 4 * (n - 128);
          r = 255;
        end else begin
          b = (4 * (n - 191)) & 'hFF;
          g = 255;
          r = 255;
        end
      end
      MODE_GRAY: begin
        r = idx;
        g = idx;
        b = idx;
      end
      MODE_RAINBOW: begin
        n = (240 * idx) / 255;
        if (n < 60) begin
          b = 255;
          g = 4 * n;
        end else if (n < 120) begin
          b = 4 * (120 - n);
          g = 255;
        end else if (n < 180) begin
          g = 255;
          r = 4 * (n - 119);
        end else begin
          g = 4 * (240 - n);
          r = 255;
        end
      end
      default: ;  // black
    endcase
    return 16'(((b & 'hF8) >> 3) | ((g & 'hF8) << 3) | ((r & 'hF8) << 8));
  endfunction

  // Mostly inside the frame range, the rest anywhere in 16 bits
  function automatic logic [15:0] rand_sample();
    int span;
    span = int'(frame_max_r) - int'(frame_min_r);
    if (span >= 0 && $urandom_range(0, 9) < 7)
      return 16'(int'(frame_min_r) + int'($urandom_range(0, span)));
    return 16'($urandom);
  endfunction

  // Driver: raise a new transaction only once the previous one is taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) pixel_q.push_back(pixel_for(s_tdata));
      if (!s_tvalid || s_tready) begin
        if (sample_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= sample_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready: long hold-off on request, random stalls otherwise
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_cnt = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Monitor: compare each result transaction with the oldest expected pixel
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected pixel %h", $time, m_tdata);
        err_cnt++;
      end else begin
        if (m_tdata !== pixel_q[0]) begin
          $display("%0t: pixel mismatch, expected %h actual %h",
                   $time, pixel_q[0], m_tdata);
          err_cnt++;
        end
        void'(pixel_q.pop_front());
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("tb_thermal_false_color_mapper_top: done, errors");
      $finish;
    end
  end

  task automatic cfg_write(cfg_reg_t addr, logic [15:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    case (addr)
      REG_FRAME_MAX:    frame_max_r = data;
      REG_FRAME_MIN:    frame_min_r = data;
      REG_PALETTE_MODE: mode_r = palette_mode_t'(data[1:0]);
      default: ;  // unused index, write ignored
    endcase
  endtask

  // Program a frame range and palette; upper mode bits are don't-care
  task automatic set_frame(logic [15:0] fmax, logic [15:0] fmin, palette_mode_t mode);
    cfg_write(REG_FRAME_MAX, fmax);
    cfg_write(REG_FRAME_MIN, fmin);
    cfg_write(REG_PALETTE_MODE, {14'($urandom), mode});
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Wait until every queued sample is sent and every pixel has returned
  task automatic wait_drained();
    while (sample_q.size() > 0 || s_tvalid || pixel_q.size() > 0) @(negedge clk);
  endtask

  task automatic push_samples(logic [15:0] vals[]);
    foreach (vals[i]) sample_q.push_back(vals[i]);
  endtask

  // Sequencer
  initial begin
    int lo, hi;
    palette_mode_t mode;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset configuration: range 0..255, iron; extremes and out-of-range wrap
    push_samples('{16'h0000, 16'd255, 16'hFFFF, 16'd256, 16'h8000, 16'h7FFF});
    wait_drained();

    // Widest range in grayscale
    set_frame(16'h7FFF, 16'h8000, MODE_GRAY);
    push_samples('{16'h8000, 16'h7FFF, 16'h0000});
    wait_drained();

    // Rainbow across its ramps
    set_frame(16'd255, 16'd0, MODE_RAINBOW);
    push_samples('{16'd0, 16'd63, 16'd127, 16'd191, 16'd255, 16'd300});
    wait_drained();

    // Unused palette gives black; a write to the unused register is ignored
    set_frame(16'd255, 16'd0, MODE_BLACK);
    cfg_write(REG_UNUSED, 16'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    push_samples('{16'd5, 16'hFFFB});
    wait_drained();

    // Zero divisor: max = min - 2
    set_frame(16'd100, 16'd102, MODE_GRAY);
    push_samples('{16'd100, 16'h8000});
    wait_drained();

    // Negative divisor: max far below min
    set_frame(16'h8000, 16'h7FFF, MODE_GRAY);
    push_samples('{16'h0000, 16'h7FFF, 16'h8000});
    wait_drained();

    // Random phases over idle patterns, palettes and frame ranges
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 47; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 47; end
        default: begin idle_pct = 6; stall_pct = 6; end
      endcase
      mode = palette_mode_t'((p + p / 4) % 4);
      if (p == 0) begin
        lo = -32768;
        hi = 32767;
      end else begin
        lo = int'($urandom_range(0, 65535)) - 32768;
        if ($urandom_range(0, 1)) begin
          hi = lo + int'($urandom_range(0, 2000));
          if (hi > 32767) hi = 32767;
        end else begin
          hi = int'($urandom_range(0, 65535)) - 32768;
        end
      end
      set_frame(16'(hi), 16'(lo), mode);
      for (int i = 0; i < PHASE_ITEMS / 2; i++) sample_q.push_back(rand_sample());
      // back-pressure until the pipeline fills and input stalls
      if (p == 4) hold_req++;
      // sender pauses until all pixels are back
      wait_drained();
      for (int i = 0; i < PHASE_ITEMS / 2; i++) sample_q.push_back(rand_sample());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pixel_q.size() != 0) begin
      $display("%0t: %0d pixels never arrived, expected %h actual none",
               $time, pixel_q.size(), pixel_q[0]);
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("tb_thermal_false_color_mapper_top: done, clean");
    end else begin
      $display("tb_thermal_false_color_mapper_top: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
